@@ rtl/core/rgba_alpha_blend_defines.svh @@
// Assertion macros for the RGBA alpha blend checker.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef RGBA_ALPHA_BLEND_DEFINES_SVH
`define RGBA_ALPHA_BLEND_DEFINES_SVH

// Clocked property that is switched off while reset is asserted.
`define RAB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that must hold in reset as well.
`define RAB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/rab_pkg.sv @@
// Shared types, constants and a helper function of the RGBA alpha blend block.
// Depends on nothing; weight, lane, merge and top refer to it by scoped names.
package rab_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned AlphaW    = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned QOne      = 32768;
  localparam int unsigned FullScale = 255 * QOne;
  // Widest lane weight is the full scale 255 * 32768, which needs 23 bits.
  localparam int unsigned WeightW   = 23;
  // Lane sum after the divide by 32768; at most 255 * 255.
  localparam int unsigned SumW      = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOverlayMode = 8'd0,
    CfgAlphaQ      = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] first_red;
    logic [ChanW-1:0] first_green;
    logic [ChanW-1:0] first_blue;
    logic [ChanW-1:0] first_opacity;
    logic [ChanW-1:0] second_red;
    logic [ChanW-1:0] second_green;
    logic [ChanW-1:0] second_blue;
    logic [ChanW-1:0] second_opacity;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_opacity;
  } pix_out_t;

  // Weights shared by the lanes: one pair for the colour lanes, one for alpha.
  typedef struct packed {
    logic [WeightW-1:0] col_w1;
    logic [WeightW-1:0] col_w2;
    logic [WeightW-1:0] alp_w1;
    logic [WeightW-1:0] alp_w2;
  } weight_t;

  // Exact floor(v / 255) for v below 255 * 256.
  function automatic logic [ChanW-1:0] div255(input logic [SumW-1:0] v);
    logic [SumW:0] t;
    t = {1'b0, v} + (SumW+1)'(1) + {{(SumW+1-ChanW){1'b0}}, v[SumW-1:ChanW]};
    return t[SumW-1:ChanW];
  endfunction

endpackage

@@ rtl/core/rab_weight.sv @@
// Blend weight stage: turns the mode, the clamped weight and the second alpha
// into registered lane weights. Depends on rab_pkg.
module rab_weight (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          overlay_i,
  input  logic [rab_pkg::AlphaW-1:0]    al_i,
  input  logic [rab_pkg::ChanW-1:0]     a2_i,
  output rab_pkg::weight_t              wts_o
);

  localparam int unsigned TopW = rab_pkg::ChanW + rab_pkg::AlphaW;

  logic [TopW-1:0]                           top;
  logic [rab_pkg::AlphaW-1:0]                nb;
  rab_pkg::weight_t                          wts_d, wts_q;

  always_comb begin
    top = TopW'(a2_i) * TopW'(al_i);
    nb  = rab_pkg::AlphaW'(rab_pkg::QOne) - al_i;
    if (overlay_i) begin
      // Overlay: the second alpha scales the second pixel over the first.
      wts_d.col_w1 = rab_pkg::WeightW'(rab_pkg::FullScale) - top[rab_pkg::WeightW-1:0];
      wts_d.col_w2 = top[rab_pkg::WeightW-1:0];
      wts_d.alp_w1 = rab_pkg::WeightW'(rab_pkg::QOne);
      wts_d.alp_w2 = '0;
    end else begin
      wts_d.col_w1 = rab_pkg::WeightW'(nb);
      wts_d.col_w2 = rab_pkg::WeightW'(al_i);
      wts_d.alp_w1 = rab_pkg::WeightW'(nb);
      wts_d.alp_w2 = rab_pkg::WeightW'(al_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wts_q <= wts_d;
    end
  end

  assign wts_o = wts_q;

endmodule

@@ rtl/core/rab_lane.sv @@
// One blend lane: product or bare operand, then weighted sum divided by 32768.
// Depends on rab_pkg.
module rab_lane (
  input  logic                          clk_i,
  input  logic                          en_a_i,
  input  logic                          en_b_i,
  input  logic                          use_prod_i,
  input  logic [rab_pkg::ChanW-1:0]     x1_i,
  input  logic [rab_pkg::ChanW-1:0]     y1_i,
  input  logic [rab_pkg::ChanW-1:0]     x2_i,
  input  logic [rab_pkg::ChanW-1:0]     y2_i,
  input  logic [rab_pkg::WeightW-1:0]   w1_i,
  input  logic [rab_pkg::WeightW-1:0]   w2_i,
  output logic [rab_pkg::SumW-1:0]      sum_o
);

  localparam int unsigned MW = 2 * rab_pkg::ChanW;
  localparam int unsigned PW = MW + rab_pkg::WeightW;

  logic [MW-1:0]            m1_d, m2_d, m1_q, m2_q;
  logic [PW-1:0]            p1, p2;
  logic [PW:0]              total;
  logic [rab_pkg::SumW-1:0] sum_d, sum_q;

  // Stage A: either the colour times its own alpha, or the bare value.
  always_comb begin
    if (use_prod_i) begin
      m1_d = MW'(x1_i) * MW'(y1_i);
      m2_d = MW'(x2_i) * MW'(y2_i);
    end else begin
      m1_d = MW'(x1_i);
      m2_d = MW'(x2_i);
    end
  end

  // Stage B: the sum never reaches 2^31, so bits 30:15 hold the quotient by 32768.
  always_comb begin
    p1    = PW'(m1_q) * PW'(w1_i);
    p2    = PW'(m2_q) * PW'(w2_i);
    total = {1'b0, p1} + {1'b0, p2};
    sum_d = total[rab_pkg::SumW+14:15];
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
    if (en_b_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ rtl/core/rab_merge.sv @@
// Merge stage: divides the colour lane sums by 255 and packs the result beat.
// Depends on rab_pkg.
module rab_merge (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rab_pkg::SumW-1:0]      red_sum_i,
  input  logic [rab_pkg::SumW-1:0]      green_sum_i,
  input  logic [rab_pkg::SumW-1:0]      blue_sum_i,
  input  logic [rab_pkg::SumW-1:0]      alpha_sum_i,
  output rab_pkg::pix_out_t             res_o
);

  rab_pkg::pix_out_t res_d, res_q;

  always_comb begin
    res_d.out_red     = rab_pkg::div255(red_sum_i);
    res_d.out_green   = rab_pkg::div255(green_sum_i);
    res_d.out_blue    = rab_pkg::div255(blue_sum_i);
    // The alpha lane is already in 0..255 after the divide by 32768.
    res_d.out_opacity = alpha_sum_i[rab_pkg::ChanW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/rgba_alpha_blend.sv @@
// RGBA8 alpha blend: blends each pair of pixels into a single blended pixel.
// Depends on rab_pkg, rab_weight, rab_lane and rab_merge.
//
// Usage. A beat is offered on pix_i with start_i high and is taken at any
// rising edge where busy_o is low; busy_o never rises, so one pixel pair can
// be taken on every clock cycle. Each taken beat produces exactly one result
// beat on res_o, marked by done_o for one cycle: the beat moves through the
// valid bits va_q, vb_q and vc_q in turn, and done_o shows vc_q. The receiver
// has no way to stall and must take every result in the cycle it is shown;
// with a fixed latency nothing ever waits.
//
// Throughput is one beat per cycle, set by the three-stage pipeline: operands
// (products or bare values) and shared weights, then four parallel lanes (red,
// green, blue, alpha) forming the weighted sum, then the merge stage that
// divides the colour sums by 255 and registers the result.
//
// The configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i,
// cfg_data_i) is always ready. Index 0 is overlay_mode, index 1 is alpha_q;
// other indexes are ignored. Registers should only change while no beat is
// in flight. Reset clears the pipeline valid bits, sets weighted mode and a
// blend weight of one half; no results are shown until new beats arrive.
module rgba_alpha_blend (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  rab_pkg::pix_in_t                  pix_i,
  output logic                              done_o,
  output rab_pkg::pix_out_t                 res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rab_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rab_pkg::AlphaW-1:0]        cfg_data_i
);

  logic                       overlay_q;
  logic [rab_pkg::AlphaW-1:0] alpha_q_q;
  logic [rab_pkg::AlphaW-1:0] al;
  logic                       accept;
  logic                       va_q, vb_q, vc_q;
  rab_pkg::weight_t           wts;
  logic [rab_pkg::SumW-1:0]   red_sum, green_sum, blue_sum, alpha_sum;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Configuration registers. A weight above one is clamped where it is used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlay_q <= 1'b0;
      alpha_q_q <= rab_pkg::AlphaW'(rab_pkg::QOne / 2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rab_pkg::cfg_reg_e'(cfg_index_i))
        rab_pkg::CfgOverlayMode: overlay_q <= cfg_data_i[0];
        rab_pkg::CfgAlphaQ:      alpha_q_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign al = (alpha_q_q > rab_pkg::AlphaW'(rab_pkg::QOne)) ?
              rab_pkg::AlphaW'(rab_pkg::QOne) : alpha_q_q;

  // One valid bit per pipeline stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= accept;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  rab_weight u_weight (
    .clk_i     (clk_i),
    .en_i      (accept),
    .overlay_i (overlay_q),
    .al_i      (al),
    .a2_i      (pix_i.second_opacity),
    .wts_o     (wts)
  );

  // Colour lanes weight each colour by its own alpha in weighted mode only.
  rab_lane u_lane_red (
    .clk_i      (clk_i),
    .en_a_i     (accept),
    .en_b_i     (va_q),
    .use_prod_i (!overlay_q),
    .x1_i       (pix_i.first_red),
    .y1_i       (pix_i.first_opacity),
    .x2_i       (pix_i.second_red),
    .y2_i       (pix_i.second_opacity),
    .w1_i       (wts.col_w1),
    .w2_i       (wts.col_w2),
    .sum_o      (red_sum)
  );

  rab_lane u_lane_green (
    .clk_i      (clk_i),
    .en_a_i     (accept),
    .en_b_i     (va_q),
    .use_prod_i (!overlay_q),
    .x1_i       (pix_i.first_green),
    .y1_i       (pix_i.first_opacity),
    .x2_i       (pix_i.second_green),
    .y2_i       (pix_i.second_opacity),
    .w1_i       (wts.col_w1),
    .w2_i       (wts.col_w2),
    .sum_o      (green_sum)
  );

  rab_lane u_lane_blue (
    .clk_i      (clk_i),
    .en_a_i     (accept),
    .en_b_i     (va_q),
    .use_prod_i (!overlay_q),
    .x1_i       (pix_i.first_blue),
    .y1_i       (pix_i.first_opacity),
    .x2_i       (pix_i.second_blue),
    .y2_i       (pix_i.second_opacity),
    .w1_i       (wts.col_w1),
    .w2_i       (wts.col_w2),
    .sum_o      (blue_sum)
  );

  // The alpha lane blends the bare alphas; in overlay mode its weights
  // (one and zero) pass the first alpha through unchanged.
  rab_lane u_lane_alpha (
    .clk_i      (clk_i),
    .en_a_i     (accept),
    .en_b_i     (va_q),
    .use_prod_i (1'b0),
    .x1_i       (pix_i.first_opacity),
    .y1_i       (pix_i.first_opacity),
    .x2_i       (pix_i.second_opacity),
    .y2_i       (pix_i.second_opacity),
    .w1_i       (wts.alp_w1),
    .w2_i       (wts.alp_w2),
    .sum_o      (alpha_sum)
  );

  rab_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (vb_q),
    .red_sum_i   (red_sum),
    .green_sum_i (green_sum),
    .blue_sum_i  (blue_sum),
    .alpha_sum_i (alpha_sum),
    .res_o       (res_o)
  );

  assign done_o = vc_q;

endmodule

@@ rtl/core/rab_checker.sv @@
// Port-level checker for the RGBA alpha blend block, bound to the top level.
// Depends on rgba_alpha_blend_defines.svh.
`include "rgba_alpha_blend_defines.svh"

module rab_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic cfg_ready_o
);

  // Every taken beat is followed by its result beat on done_o.
  `RAB_ASSERT(a_result_follows, (start_i && !busy_o) |=> ##2 done_o, "result beat missing")

  // No result beat appears on done_o without an earlier taken beat.
  `RAB_ASSERT(a_no_phantom, done_o |-> $past(start_i && !busy_o, 3), "unexpected result beat")

  // Both channels are always open, in reset too.
  `RAB_ASSERT_ALWAYS(a_always_open, !busy_o && cfg_ready_o, "channel closed")

endmodule

bind rgba_alpha_blend rab_checker u_rab_checker (.*);

@@ tb/sv/rgba_alpha_blend_sb_pkg.sv @@
// Scoreboard for the RGBA alpha blend testbench: blend predictor and result check.
// Depends on rab_pkg for the pixel beat types and the register index names.
package rgba_alpha_blend_sb_pkg;

  localparam longint unsigned UnitWeight  = 64'd32768;
  localparam longint unsigned ColourScale = 64'd255 * 64'd32768;

  class blend_scoreboard;
    bit                  overlay_on;
    logic [15:0]         blend_weight;
    rab_pkg::pix_out_t   expected_pixels[$];
    int unsigned         pairs_taken;
    int unsigned         pixels_checked;
    int unsigned         reg_writes;
    int unsigned         mismatches;

    function new();
      overlay_on   = 1'b0;
      blend_weight = 16'd16384;
    endfunction

    function void write_reg(logic [rab_pkg::CfgIdxW-1:0] index,
                            logic [rab_pkg::AlphaW-1:0] data);
      reg_writes++;
      if (index == rab_pkg::CfgOverlayMode) begin
        overlay_on = data[0];
      end else if (index == rab_pkg::CfgAlphaQ) begin
        blend_weight = data;
      end
    endfunction

    // One colour channel; w is the weight of the second pixel, already clamped.
    function logic [7:0] colour_lane(input longint unsigned c1, c2, a1, a2, w);
      longint unsigned top;
      if (overlay_on) begin
        top = a2 * w;
        return 8'((c1 * (ColourScale - top) + c2 * top) / ColourScale);
      end
      return 8'((c1 * a1 * (UnitWeight - w) + c2 * a2 * w) / ColourScale);
    endfunction

    function rab_pkg::pix_out_t blend_pixel(rab_pkg::pix_in_t p);
      rab_pkg::pix_out_t r;
      longint unsigned   w;
      longint unsigned   a1;
      longint unsigned   a2;
      w  = (blend_weight > UnitWeight) ? UnitWeight : 64'(blend_weight);
      a1 = 64'(p.first_opacity);
      a2 = 64'(p.second_opacity);
      r.out_red   = colour_lane(64'(p.first_red), 64'(p.second_red), a1, a2, w);
      r.out_green = colour_lane(64'(p.first_green), 64'(p.second_green), a1, a2, w);
      r.out_blue  = colour_lane(64'(p.first_blue), 64'(p.second_blue), a1, a2, w);
      if (overlay_on) begin
        r.out_opacity = p.first_opacity;
      end else begin
        r.out_opacity = 8'((a1 * (UnitWeight - w) + a2 * w) / UnitWeight);
      end
      return r;
    endfunction

    function void note_pair(rab_pkg::pix_in_t p);
      expected_pixels.push_back(blend_pixel(p));
      pairs_taken++;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                  pixels_checked, name, got, want));
      end
    endtask

    task check_result(rab_pkg::pix_out_t got);
      rab_pkg::pix_out_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %h with no pixel pair outstanding", got));
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("out_red", got.out_red, want.out_red);
      compare_field("out_green", got.out_green, want.out_green);
      compare_field("out_blue", got.out_blue, want.out_blue);
      compare_field("out_opacity", got.out_opacity, want.out_opacity);
      pixels_checked++;
    endtask
  endclass

endpackage

@@ tb/sv/rgba_alpha_blend_tb.sv @@
// Top-level testbench of rgba_alpha_blend: drives pixel pairs and register writes.
// Depends on rab_pkg and rgba_alpha_blend_sb_pkg; needs nothing but the RTL.
module rgba_alpha_blend_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block's result for a pixel pair comes out of its pipeline, of depth
  // PipeDepth; pauses between register settings allow for that plus margin.
  localparam int PipeDepth      = 3;
  localparam int QuietLimit     = 2000;
  localparam int RandomPhases   = 8;
  localparam int PairsPerPhase  = 150;

  // Indexes that name no register; writes to them must leave the block as is.
  localparam logic [rab_pkg::CfgIdxW-1:0] IdxFirstUnused = 8'd2;
  localparam logic [rab_pkg::CfgIdxW-1:0] IdxLastUnused  = 8'hFF;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  rab_pkg::pix_in_t              pix_i;
  logic                          done_o;
  rab_pkg::pix_out_t             res_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [rab_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [rab_pkg::AlphaW-1:0]    cfg_data_i;

  rgba_alpha_blend_sb_pkg::blend_scoreboard sb = new();
  int unsigned     quiet_cycles;
  int unsigned     directed_pairs;

  rgba_alpha_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pix_i       (pix_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Monitor. Everything is sampled at the rising edge, before the block's own
  // registers update, so the scoreboard sees exactly the beats the block takes.
  // Register writes are applied to the predictor as they happen; the stimulus
  // only writes while nothing is in flight, so the order within an edge is moot.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(res_o);
      end
      if (start_i && !busy_o) begin
        sb.note_pair(pix_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(cfg_index_i, cfg_data_i);
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress. A run that stalls
  // for too long (lost result, stuck busy, dead config channel) ends here.
  always @(posedge clk_i) begin
    if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, sb.pending());
      $display("rgba_alpha_blend_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one pixel pair, first idling for a random number of cycles. While
  // idle, start_i is low and pix_i carries junk the block must ignore. The
  // task returns right after the edge that took the beat, with start_i still
  // high, so back-to-back calls with idle_pct zero keep one beat per cycle.
  task automatic send_pixel(input rab_pkg::pix_in_t p, input int idle_pct);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) < idle_pct) begin
        start_i <= 1'b0;
        pix_i   <= {$urandom, $urandom};
      end else begin
        start_i <= 1'b1;
        pix_i   <= p;
        break;
      end
    end
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Drops start_i, waits for every outstanding result and then for the
  // pipeline depth, so the block is idle before registers change.
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // One beat on the configuration channel.
  task automatic write_reg_beat(input logic [rab_pkg::CfgIdxW-1:0] index,
                                input logic [rab_pkg::AlphaW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random pixel pair; each byte is sometimes forced to an extreme so the
  // fully transparent and fully opaque corners come up often.
  function automatic rab_pkg::pix_in_t random_pair();
    rab_pkg::pix_in_t p;
    int               b;
    p = {$urandom, $urandom};
    for (b = 0; b < 8; b++) begin
      if ($urandom_range(5) == 0) begin
        p[b*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
    end
    return p;
  endfunction

  initial begin
    int                         idle_pct;
    bit                         mode;
    logic [rab_pkg::AlphaW-1:0] weight;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    pix_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting in the reset setting: weighted mode, half weight.
    // Field order in each literal is first RGBA, then second RGBA.
    send_pixel(64'h0000_0000_0000_0000, 0);
    send_pixel(64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_pixel(64'hFFFF_FFFF_0000_0000, 0);
    send_pixel(64'hAAAA_AAAA_5555_5555, 0);
    send_pixel(64'h5555_5555_AAAA_AAAA, 0);

    // Weight zero: the second pixel drops out entirely.
    settle();
    write_reg_beat(rab_pkg::CfgAlphaQ, 16'd0);
    send_pixel(64'h1080_F0FF_EE22_7780, 0);

    // Weight one: the first pixel drops out.
    settle();
    write_reg_beat(rab_pkg::CfgAlphaQ, 16'd32768);
    send_pixel(64'h1080_F0FF_EE22_7780, 0);
    send_pixel(64'h0000_00FF_FFFF_FF00, 0);

    // A weight above one must saturate to one and keep all bytes in range.
    settle();
    write_reg_beat(rab_pkg::CfgAlphaQ, 16'hFFFF);
    send_pixel(64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_pixel(64'h1080_F0FF_EE22_7780, 0);

    // Overlay mode, written with extra high bits that must be dropped.
    settle();
    write_reg_beat(rab_pkg::CfgOverlayMode, 16'h0003);
    send_pixel(64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_pixel(64'hFF00_FFFF_00FF_00FF, 0);

    settle();
    write_reg_beat(rab_pkg::CfgAlphaQ, 16'd0);
    send_pixel(64'h1234_56C8_9ABC_DE7F, 0);

    settle();
    write_reg_beat(rab_pkg::CfgAlphaQ, 16'd32768);
    send_pixel(64'h1234_56C8_9ABC_DE7F, 0);
    send_pixel(64'h00FF_0080_FF00_FFFF, 0);

    // A write to an index that names no register changes nothing.
    settle();
    write_reg_beat(IdxFirstUnused, 16'd0);
    send_pixel(64'h8040_2001_0204_08FE, 0);

    // Back to weighted mode through a value whose low bit is clear.
    settle();
    write_reg_beat(rab_pkg::CfgOverlayMode, 16'hFFFE);
    send_pixel(64'h8040_2001_0204_08FE, 0);
    directed_pairs = sb.pairs_taken;

    // Random part. Each phase picks a mode and a weight (the extremes among
    // them) and a sender idle rate; the rates rotate through none, heavy,
    // none and light so both modes run with and without gaps.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      mode = phase[0] ^ phase[1];
      case (phase % 4)
        1:       idle_pct = 71;
        3:       idle_pct = 23;
        default: idle_pct = 0;
      endcase
      case (phase)
        0:       weight = 16'd0;
        1:       weight = 16'd32768;
        3:       weight = 16'hFFFF;
        4:       weight = 16'($urandom_range(16'hFFFF));
        5:       weight = 16'd1;
        6:       weight = 16'd32767;
        default: weight = 16'($urandom_range(32768));
      endcase
      settle();
      write_reg_beat(rab_pkg::CfgOverlayMode, (16'($urandom) & 16'hFFFE) | {15'd0, mode});
      write_reg_beat(rab_pkg::CfgAlphaQ, weight);
      // Junk write to an unused index after the real ones, so a decode bug
      // that lets it through would corrupt the setting under test.
      write_reg_beat(phase[0] ? IdxLastUnused : IdxFirstUnused, 16'($urandom));
      for (int n = 0; n < PairsPerPhase; n++) begin
        send_pixel(random_pair(), idle_pct);
      end
    end

    settle();
    $display("covered %0d pixel pairs (%0d directed), %0d results checked",
             sb.pairs_taken, directed_pairs, sb.pixels_checked);
    $display("both blend modes, %0d register writes, weights from zero to saturation",
             sb.reg_writes);
    if (sb.mismatches == 0) begin
      $display("rgba_alpha_blend_tb: PASS");
    end else begin
      $display("%0d field mismatches", sb.mismatches);
      $display("rgba_alpha_blend_tb: FAIL");
    end
    $finish;
  end

endmodule
